/* hdl/pdivb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdivb_pkg
// Shared widths, codes, command/status types and the saturating scale
// function of the eight-wave div(B) source term block.
// ----------------------------------------------------------------------------
package pdivb_pkg;

  localparam int FRAC_BITS = 16;

  localparam int WORD_W    = 32;
  localparam int AREA_W    = 31;
  localparam int MULA_W    = 32;
  localparam int MULB_W    = 33;
  localparam int PROD_W    = MULA_W + MULB_W;
  // area flux, (field * area) >> FRAC_BITS
  localparam int FLUX_W    = 63 - FRAC_BITS;
  localparam int DIFF_W    = FLUX_W + 1;
  // v.B, sum of three (v * b) >> FRAC_BITS
  localparam int VB_W      = 65 - FRAC_BITS;
  localparam int ACC_W     = 96 - FRAC_BITS;
  localparam int REM_W     = AREA_W;
  localparam int DIV_STEPS = 32;
  localparam int MUL_STEPS = 8;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UPWIND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 1'b1;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic [WORD_W-1:0]        Q_NEG_LIMIT = 32'h8000_0000;
  localparam logic signed [ACC_W-1:0]  ACC_S32_MAX = ACC_W'(S32_MAX);
  localparam logic signed [ACC_W-1:0]  ACC_S32_MIN = ACC_W'(S32_MIN);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUX,
    S_DIFF,
    S_SETUP,
    S_DIV,
    S_DV,
    S_MUL,
    S_DRAIN,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_FLUX,
    MOP_VB_X,
    MOP_VB_Y,
    MOP_VB_Z,
    MOP_MOM_X,
    MOP_MOM_Y,
    MOP_MOM_Z,
    MOP_IND_X,
    MOP_IND_Y,
    MOP_IND_Z,
    MOP_EN_LO,
    MOP_EN_HI
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    mul_op_t mul_op;
    logic    setup;
    logic    div_step;
    logic    dv_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_start;
    logic vol_zero;
  } sts_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     sat;
  } sat_res_t;

  // -floor(p / 2^FRAC_BITS), clamped to 32 bits
  function automatic sat_res_t neg_scale_sat(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] r;
    sat_res_t                res;
    t = p >>> FRAC_BITS;
    r = -t;
    if (r > ACC_S32_MAX) begin
      res.value = S32_MAX;
      res.sat   = 1'b1;
    end else if (r < ACC_S32_MIN) begin
      res.value = S32_MIN;
      res.sat   = 1'b1;
    end else begin
      res.value = r[WORD_W-1:0];
      res.sat   = 1'b0;
    end
    return res;
  endfunction

endpackage

/* hdl/powell_divb_source_term_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// powell_divb_source_term_top
// Eight-wave div(B) source terms for one cell per item, signed fixed point
// with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// in      | in        | in_valid / in_ready  | sweep start, interface and cell data
// out     | out       | out_valid / out_ready| div_b, sources, arith_fault
//
// Each cell goes through the radix-2 divider and passes of the shared 32x33
// multiplier and its post stage; energy off skips the two energy passes.
// A sweep start item only updates the previous area flux; a zero-volume
// cell skips divider and multiplier. Reset is synchronous; nothing is swept.
// A result waits in the output register while the next item is taken; the
// block stalls before loading a new result until the old one is taken.
// ----------------------------------------------------------------------------
module powell_divb_source_term_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pdivb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdivb_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  sweep_start,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   normal_field_left,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   normal_field_right,
  input  logic                                  mass_flux_negative,
  input  logic [pdivb_pkg::AREA_W-1:0]          face_area,
  input  logic [pdivb_pkg::AREA_W-1:0]          cell_volume,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_x,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_y,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_z,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_x,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_y,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pdivb_pkg::WORD_W-1:0]   div_b,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_x,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_y,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_z,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_x,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_y,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_z,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_energy,
  output logic                                  arith_fault
);

  logic            upwind_mode;
  logic            energy_enable;
  pdivb_pkg::cmd_t cmd;
  pdivb_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      upwind_mode   <= 1'b0;
      energy_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdivb_pkg::CFG_UPWIND: upwind_mode   <= cfg_data[0];
        pdivb_pkg::CFG_ENERGY: energy_enable <= cfg_data[0];
      endcase
    end
  end

  pdivb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .energy_enable (energy_enable),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  pdivb_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .upwind_mode        (upwind_mode),
    .energy_enable      (energy_enable),
    .sweep_start        (sweep_start),
    .normal_field_left  (normal_field_left),
    .normal_field_right (normal_field_right),
    .mass_flux_negative (mass_flux_negative),
    .face_area          (face_area),
    .cell_volume        (cell_volume),
    .vel_x              (vel_x),
    .vel_y              (vel_y),
    .vel_z              (vel_z),
    .mag_x              (mag_x),
    .mag_y              (mag_y),
    .mag_z              (mag_z),
    .div_b              (div_b),
    .src_mom_x          (src_mom_x),
    .src_mom_y          (src_mom_y),
    .src_mom_z          (src_mom_z),
    .src_ind_x          (src_ind_x),
    .src_ind_y          (src_ind_y),
    .src_ind_z          (src_ind_z),
    .src_energy         (src_energy),
    .arith_fault        (arith_fault)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without an item in progress");

  a_flux_follows_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.mul_op == pdivb_pkg::MOP_FLUX)
    else $error("area flux multiply not issued after capture");

endmodule

/* hdl/pdivb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdivb_ctrl
// Sequencer: input handshake, divider and multiplier scheduling, output
// register handshake.
// ----------------------------------------------------------------------------
module pdivb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              energy_enable,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pdivb_pkg::sts_t   sts,
  output pdivb_pkg::cmd_t   cmd
);

  pdivb_pkg::state_t               state;
  pdivb_pkg::state_t               state_next;
  logic [pdivb_pkg::CNT_W-1:0]     cnt;
  logic [pdivb_pkg::CNT_W-1:0]     mul_last;

  assign mul_last = energy_enable ? pdivb_pkg::CNT_W'(pdivb_pkg::MUL_STEPS - 1)
                                  : pdivb_pkg::CNT_W'(pdivb_pkg::MUL_STEPS - 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdivb_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == pdivb_pkg::S_DIV || state == pdivb_pkg::S_MUL) &&
          state_next == state) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pdivb_pkg::S_IDLE:  if (in_valid) state_next = pdivb_pkg::S_FLUX;
      pdivb_pkg::S_FLUX:  state_next = pdivb_pkg::S_DIFF;
      pdivb_pkg::S_DIFF: begin
        if (sts.sweep_start)   state_next = pdivb_pkg::S_IDLE;
        else if (sts.vol_zero) state_next = pdivb_pkg::S_OUT;
        else                   state_next = pdivb_pkg::S_SETUP;
      end
      pdivb_pkg::S_SETUP: state_next = pdivb_pkg::S_DIV;
      pdivb_pkg::S_DIV: begin
        if (cnt == pdivb_pkg::CNT_W'(pdivb_pkg::DIV_STEPS - 1)) state_next = pdivb_pkg::S_DV;
      end
      pdivb_pkg::S_DV:    state_next = pdivb_pkg::S_MUL;
      pdivb_pkg::S_MUL:   if (cnt == mul_last) state_next = pdivb_pkg::S_DRAIN;
      pdivb_pkg::S_DRAIN: state_next = pdivb_pkg::S_OUT;
      pdivb_pkg::S_OUT:   if (!out_valid || out_ready) state_next = pdivb_pkg::S_IDLE;
      default:            state_next = pdivb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_op   = pdivb_pkg::MOP_NONE;
    in_ready     = 1'b0;
    unique case (state)
      pdivb_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pdivb_pkg::S_FLUX:  cmd.mul_op = pdivb_pkg::MOP_FLUX;
      pdivb_pkg::S_DIFF:  ;
      pdivb_pkg::S_SETUP: cmd.setup = 1'b1;
      pdivb_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        // the multiplier is free during the divide: build v.B here
        unique case (cnt)
          pdivb_pkg::CNT_W'(0): cmd.mul_op = pdivb_pkg::MOP_VB_X;
          pdivb_pkg::CNT_W'(1): cmd.mul_op = pdivb_pkg::MOP_VB_Y;
          pdivb_pkg::CNT_W'(2): cmd.mul_op = pdivb_pkg::MOP_VB_Z;
          default:              cmd.mul_op = pdivb_pkg::MOP_NONE;
        endcase
      end
      pdivb_pkg::S_DV:    cmd.dv_load = 1'b1;
      pdivb_pkg::S_MUL: begin
        unique case (cnt)
          pdivb_pkg::CNT_W'(0): cmd.mul_op = pdivb_pkg::MOP_MOM_X;
          pdivb_pkg::CNT_W'(1): cmd.mul_op = pdivb_pkg::MOP_MOM_Y;
          pdivb_pkg::CNT_W'(2): cmd.mul_op = pdivb_pkg::MOP_MOM_Z;
          pdivb_pkg::CNT_W'(3): cmd.mul_op = pdivb_pkg::MOP_IND_X;
          pdivb_pkg::CNT_W'(4): cmd.mul_op = pdivb_pkg::MOP_IND_Y;
          pdivb_pkg::CNT_W'(5): cmd.mul_op = pdivb_pkg::MOP_IND_Z;
          pdivb_pkg::CNT_W'(6): cmd.mul_op = pdivb_pkg::MOP_EN_LO;
          pdivb_pkg::CNT_W'(7): cmd.mul_op = pdivb_pkg::MOP_EN_HI;
          default:              cmd.mul_op = pdivb_pkg::MOP_NONE;
        endcase
      end
      pdivb_pkg::S_DRAIN: ;
      pdivb_pkg::S_OUT:   cmd.out_load = !out_valid || out_ready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/pdivb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdivb_dp
// Datapath: input capture, shared 32x33 multiplier with a post stage,
// radix-2 restoring divider, saturation and the output register.
// ----------------------------------------------------------------------------
module pdivb_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pdivb_pkg::cmd_t                       cmd,
  output pdivb_pkg::sts_t                       sts,
  input  logic                                  upwind_mode,
  input  logic                                  energy_enable,
  input  logic                                  sweep_start,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   normal_field_left,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   normal_field_right,
  input  logic                                  mass_flux_negative,
  input  logic [pdivb_pkg::AREA_W-1:0]          face_area,
  input  logic [pdivb_pkg::AREA_W-1:0]          cell_volume,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_x,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_y,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   vel_z,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_x,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_y,
  input  logic signed [pdivb_pkg::WORD_W-1:0]   mag_z,
  output logic signed [pdivb_pkg::WORD_W-1:0]   div_b,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_x,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_y,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_mom_z,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_x,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_y,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_ind_z,
  output logic signed [pdivb_pkg::WORD_W-1:0]   src_energy,
  output logic                                  arith_fault
);

  localparam int W = pdivb_pkg::WORD_W;

  // captured item
  logic                                 start;
  logic signed [W-1:0]                  bn;
  logic [pdivb_pkg::AREA_W-1:0]         area;
  logic [pdivb_pkg::AREA_W-1:0]         vol;
  logic signed [W-1:0]                  vel [3];
  logic signed [W-1:0]                  mag [3];

  // multiplier
  logic signed [pdivb_pkg::MULA_W-1:0]  mul_a;
  logic signed [pdivb_pkg::MULB_W-1:0]  mul_b;
  logic signed [pdivb_pkg::PROD_W-1:0]  prod;
  pdivb_pkg::mul_op_t                   op_d;
  pdivb_pkg::sat_res_t                  prod_sat;
  pdivb_pkg::sat_res_t                  en_sat;
  logic signed [pdivb_pkg::FLUX_W-1:0]  cur;

  // flux, divide and accumulate state
  logic signed [pdivb_pkg::FLUX_W-1:0]  prev_area_flux;
  logic signed [pdivb_pkg::DIFF_W-1:0]  diff;
  logic [pdivb_pkg::DIFF_W-1:0]         diff_mag;
  logic                                 diff_neg;
  logic                                 q_ovf;
  logic [pdivb_pkg::REM_W-1:0]          rem;
  logic [W-1:0]                         dlo;
  logic [W-1:0]                         quo;
  logic [pdivb_pkg::REM_W:0]            trial;
  logic                                 trial_ge;
  logic signed [W-1:0]                  dv;
  logic signed [W-1:0]                  dv_calc;
  logic                                 dv_sat;
  logic signed [pdivb_pkg::VB_W-1:0]    vb;
  logic signed [pdivb_pkg::ACC_W-1:0]   acc;
  logic signed [W-1:0]                  src [6];
  logic                                 sat_acc;

  logic signed [W:0]                    bn_sum;
  logic signed [W-1:0]                  bn_next;

  assign sts.sweep_start = start;
  assign sts.vol_zero    = (vol == '0);

  always_comb begin
    bn_sum = '0;
    if (upwind_mode) begin
      bn_next = mass_flux_negative ? normal_field_right : normal_field_left;
    end else begin
      bn_sum  = (W + 1)'(normal_field_left) + (W + 1)'(normal_field_right);
      bn_next = W'(bn_sum >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start  <= sweep_start;
      bn     <= bn_next;
      area   <= face_area;
      vol    <= cell_volume;
      vel[0] <= vel_x;
      vel[1] <= vel_y;
      vel[2] <= vel_z;
      mag[0] <= mag_x;
      mag[1] <= mag_y;
      mag[2] <= mag_z;
    end
  end

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      pdivb_pkg::MOP_FLUX: begin
        mul_a = bn;
        mul_b = {2'b00, area};
      end
      pdivb_pkg::MOP_VB_X:  begin mul_a = vel[0]; mul_b = pdivb_pkg::MULB_W'(mag[0]); end
      pdivb_pkg::MOP_VB_Y:  begin mul_a = vel[1]; mul_b = pdivb_pkg::MULB_W'(mag[1]); end
      pdivb_pkg::MOP_VB_Z:  begin mul_a = vel[2]; mul_b = pdivb_pkg::MULB_W'(mag[2]); end
      pdivb_pkg::MOP_MOM_X: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(mag[0]); end
      pdivb_pkg::MOP_MOM_Y: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(mag[1]); end
      pdivb_pkg::MOP_MOM_Z: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(mag[2]); end
      pdivb_pkg::MOP_IND_X: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(vel[0]); end
      pdivb_pkg::MOP_IND_Y: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(vel[1]); end
      pdivb_pkg::MOP_IND_Z: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(vel[2]); end
      // v.B is too wide for one pass: low 32 bits unsigned, then the signed top
      pdivb_pkg::MOP_EN_LO: begin mul_a = dv; mul_b = {1'b0, vb[W-1:0]}; end
      pdivb_pkg::MOP_EN_HI: begin mul_a = dv; mul_b = pdivb_pkg::MULB_W'(vb >>> W); end
      default:              ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= pdivb_pkg::PROD_W'(mul_a) * pdivb_pkg::PROD_W'(mul_b);
    if (rst) begin
      op_d <= pdivb_pkg::MOP_NONE;
    end else begin
      op_d <= cmd.mul_op;
    end
  end

  assign prod_sat = pdivb_pkg::neg_scale_sat(pdivb_pkg::ACC_W'(prod));
  assign en_sat   = pdivb_pkg::neg_scale_sat(acc);
  assign cur      = pdivb_pkg::FLUX_W'(prod >>> pdivb_pkg::FRAC_BITS);

  // previous area flux is model state: cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_area_flux <= '0;
    end else if (op_d == pdivb_pkg::MOP_FLUX) begin
      prev_area_flux <= cur;
    end
  end

  // post stage of the multiplier
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      vb <= '0;
    end
    unique case (op_d)
      pdivb_pkg::MOP_FLUX: begin
        diff <= pdivb_pkg::DIFF_W'(cur) - pdivb_pkg::DIFF_W'(prev_area_flux);
      end
      pdivb_pkg::MOP_VB_X, pdivb_pkg::MOP_VB_Y, pdivb_pkg::MOP_VB_Z: begin
        vb <= vb + pdivb_pkg::VB_W'(prod >>> pdivb_pkg::FRAC_BITS);
      end
      pdivb_pkg::MOP_MOM_X: src[0] <= prod_sat.value;
      pdivb_pkg::MOP_MOM_Y: src[1] <= prod_sat.value;
      pdivb_pkg::MOP_MOM_Z: src[2] <= prod_sat.value;
      pdivb_pkg::MOP_IND_X: src[3] <= prod_sat.value;
      pdivb_pkg::MOP_IND_Y: src[4] <= prod_sat.value;
      pdivb_pkg::MOP_IND_Z: src[5] <= prod_sat.value;
      pdivb_pkg::MOP_EN_LO: acc <= pdivb_pkg::ACC_W'(prod);
      pdivb_pkg::MOP_EN_HI: acc <= acc + (pdivb_pkg::ACC_W'(prod) <<< W);
      default:              ;
    endcase
  end

  // divider: |diff| << FRAC_BITS over volume, one quotient bit a cycle
  assign diff_mag = diff[pdivb_pkg::DIFF_W-1] ? pdivb_pkg::DIFF_W'(-diff)
                                              : pdivb_pkg::DIFF_W'(diff);
  assign trial    = {rem, dlo[W-1]};
  assign trial_ge = (trial >= {1'b0, vol});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      diff_neg <= diff[pdivb_pkg::DIFF_W-1];
      // quotient of 2^32 or more can only saturate
      q_ovf    <= diff_mag >= (pdivb_pkg::DIFF_W'(vol) << (W - pdivb_pkg::FRAC_BITS));
      rem      <= pdivb_pkg::REM_W'(diff_mag >> (W - pdivb_pkg::FRAC_BITS));
      dlo      <= W'(diff_mag << pdivb_pkg::FRAC_BITS);
      quo      <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? pdivb_pkg::REM_W'(trial - {1'b0, vol})
                      : trial[pdivb_pkg::REM_W-1:0];
      quo <= {quo[W-2:0], trial_ge};
      dlo <= {dlo[W-2:0], 1'b0};
    end
  end

  always_comb begin
    dv_sat  = 1'b0;
    dv_calc = quo;
    if (q_ovf) begin
      dv_sat  = 1'b1;
      dv_calc = diff_neg ? pdivb_pkg::S32_MIN : pdivb_pkg::S32_MAX;
    end else if (!diff_neg) begin
      if (quo[W-1]) begin
        dv_sat  = 1'b1;
        dv_calc = pdivb_pkg::S32_MAX;
      end
    end else if (quo > pdivb_pkg::Q_NEG_LIMIT) begin
      dv_sat  = 1'b1;
      dv_calc = pdivb_pkg::S32_MIN;
    end else begin
      dv_calc = W'(-quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dv_load) begin
      dv <= dv_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sat_acc <= 1'b0;
    end else if (cmd.dv_load) begin
      sat_acc <= sat_acc | dv_sat;
    end else if (op_d == pdivb_pkg::MOP_MOM_X || op_d == pdivb_pkg::MOP_MOM_Y ||
                 op_d == pdivb_pkg::MOP_MOM_Z || op_d == pdivb_pkg::MOP_IND_X ||
                 op_d == pdivb_pkg::MOP_IND_Y || op_d == pdivb_pkg::MOP_IND_Z) begin
      sat_acc <= sat_acc | prod_sat.sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.vol_zero) begin
        div_b       <= '0;
        src_mom_x   <= '0;
        src_mom_y   <= '0;
        src_mom_z   <= '0;
        src_ind_x   <= '0;
        src_ind_y   <= '0;
        src_ind_z   <= '0;
        src_energy  <= '0;
        arith_fault <= 1'b1;
      end else begin
        div_b       <= dv;
        src_mom_x   <= src[0];
        src_mom_y   <= src[1];
        src_mom_z   <= src[2];
        src_ind_x   <= src[3];
        src_ind_y   <= src[4];
        src_ind_z   <= src[5];
        src_energy  <= energy_enable ? en_sat.value : '0;
        arith_fault <= sat_acc | (energy_enable & en_sat.sat);
      end
    end
  end

endmodule
